// ===== hdl/track_point_coordinate_extractor_top_assert.svh =====
// Assertion macros for the track point coordinate extractor.
`ifndef TRACK_POINT_COORDINATE_EXTRACTOR_TOP_ASSERT_SVH
`define TRACK_POINT_COORDINATE_EXTRACTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpce assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpce assertion failed");

`endif

// ===== hdl/tpce_pkg.sv =====
// Shared constants and types of the track point coordinate extractor.
`default_nettype none
package tpce_pkg;

   localparam int MAX_POINTS      = 8192;
   localparam int FRACTION_DIGITS = 7;

   localparam int COORD_W = 32;
   localparam int MAG_W   = 31;
   localparam int KEPT_W  = 17;
   localparam int FOUND_W = 24;
   localparam int PROD_W  = KEPT_W + FOUND_W;

   localparam logic [FOUND_W-1:0] FOUND_MAX = {FOUND_W{1'b1}};

   localparam int EVQ_DEPTH  = 4;
   localparam int RESQ_DEPTH = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TOTAL_POINTS = 1'b0;

   typedef enum logic [2:0] {
      PH_SEEK_LAT,
      PH_LAT_START,
      PH_LAT_BODY,
      PH_SEEK_LON,
      PH_LON_START,
      PH_LON_BODY
   } phase_type;

   typedef struct packed {
      logic               has_pair;
      logic               eof;
      logic [COORD_W-1:0] latitude;
      logic [COORD_W-1:0] longitude;
   } event_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] latitude;
      logic signed [COORD_W-1:0] longitude;
      logic [KEPT_W-1:0]         slot;
      logic [FOUND_W-1:0]        pair_number;
      logic                      is_summary;
      logic                      last_of_run;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/tpce_front.sv =====
// Byte parser: key matching and decimal conversion, one byte per cycle.
`default_nettype none
module tpce_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_of_file,
   output logic                      ev_push,
   output tpce_pkg::event_type       ev
);
   import tpce_pkg::*;

   localparam int SUM_W      = MAG_W + 4;
   localparam int FRAC_LIMIT = 7;
   localparam int KEY_LEN    = 5;

   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [7:0] LAT_KEY [KEY_LEN] = '{8'h6C, 8'h61, 8'h74, 8'h3D, 8'h22};
   localparam logic [7:0] LON_KEY [KEY_LEN] = '{8'h6C, 8'h6F, 8'h6E, 8'h3D, 8'h22};

   localparam logic [23:0] POW10 [8] = '{24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000,
                                         24'd100000, 24'd1000000, 24'd10000000};

   localparam logic [SUM_W-1:0] MAG_MAX = SUM_W'({MAG_W{1'b1}});

   function automatic logic [27:0] digit_scaled(input logic [3:0] d, input logic [2:0] e);
      return 28'(d) * 28'(POW10[e]);
   endfunction

   function automatic logic [COORD_W-1:0] signed_value(input logic neg,
                                                       input logic [MAG_W-1:0] mag);
      logic [COORD_W-1:0] m;
      m = {1'b0, mag};
      return neg ? (~m + COORD_W'(1)) : m;
   endfunction

   phase_type          phase_ff, phase_in, phase_mid;
   logic [2:0]         kpos_ff, kpos_in, kpos_mid, kpos_cur;
   logic [3:0]         kpos_new;
   logic               neg_ff, neg_in;
   logic               point_ff, point_in;
   logic [2:0]         fd_ff, fd_in;
   logic [MAG_W-1:0]   acc_ff, acc_in;
   logic [COORD_W-1:0] held_ff, held_in;

   // Result of offering the byte to the open number.
   logic               first;
   logic               is_digit;
   logic [3:0]         digit;
   logic [2:0]         fd_inc;
   logic [SUM_W-1:0]   int_sum, frac_add, frac_sum, sum;
   logic               num_take, num_neg, num_point;
   logic [2:0]         num_fd;
   logic [MAG_W-1:0]   num_acc;

   logic [7:0]         key_byte;
   logic               pair;
   logic [COORD_W-1:0] lon_val;

   assign first    = (phase_ff == PH_LAT_START) || (phase_ff == PH_LON_START);
   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign digit    = data_byte[3:0];
   assign fd_inc   = fd_ff + 3'd1;
   assign int_sum  = SUM_W'({acc_ff, 3'b000}) + SUM_W'({acc_ff, 1'b0})
                   + SUM_W'(digit_scaled(digit, 3'(FRAC_LIMIT)));
   assign frac_add = (fd_inc <= 3'(FRACTION_DIGITS))
                   ? SUM_W'(digit_scaled(digit, 3'(3'(FRAC_LIMIT) - fd_inc))) : '0;
   assign frac_sum = SUM_W'(acc_ff) + frac_add;

   always_comb begin
      num_take  = 1'b0;
      num_neg   = neg_ff;
      num_point = point_ff;
      num_fd    = fd_ff;
      sum       = SUM_W'(acc_ff);
      if (first && ((data_byte == CH_MINUS) || (data_byte == CH_PLUS))) begin
         num_take = 1'b1;
         num_neg  = (data_byte == CH_MINUS);
      end else if ((data_byte == CH_POINT) && !point_ff) begin
         num_take  = 1'b1;
         num_point = 1'b1;
      end else if (is_digit) begin
         num_take = 1'b1;
         if (!point_ff) begin
            sum = int_sum;
         end else if (fd_ff < 3'(FRAC_LIMIT)) begin
            num_fd = fd_inc;
            sum    = frac_sum;
         end
      end
      num_acc = (sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : sum[MAG_W-1:0];
   end

   always_comb begin
      phase_mid = phase_ff;
      kpos_mid  = kpos_ff;
      neg_in    = neg_ff;
      point_in  = point_ff;
      fd_in     = fd_ff;
      acc_in    = acc_ff;
      held_in   = held_ff;
      pair      = 1'b0;
      lon_val   = '0;

      unique case (phase_ff) inside
         PH_LAT_START, PH_LAT_BODY: begin
            if (num_take) begin
               phase_mid = PH_LAT_BODY;
               neg_in    = num_neg;
               point_in  = num_point;
               fd_in     = num_fd;
               acc_in    = num_acc;
            end else begin
               held_in   = signed_value(neg_ff, acc_ff);
               phase_mid = PH_SEEK_LON;
               kpos_mid  = 3'd0;
            end
         end
         PH_LON_START, PH_LON_BODY: begin
            if (num_take) begin
               phase_mid = PH_LON_BODY;
               neg_in    = num_neg;
               point_in  = num_point;
               fd_in     = num_fd;
               acc_in    = num_acc;
            end else begin
               pair      = 1'b1;
               lon_val   = signed_value(neg_ff, acc_ff);
               phase_mid = PH_SEEK_LAT;
               kpos_mid  = 3'd0;
            end
         end
         default: begin
         end
      endcase

      // The byte that ends a number is still offered to the key search.
      phase_in = phase_mid;
      kpos_in  = kpos_mid;
      kpos_cur = (kpos_mid > 3'(KEY_LEN - 1)) ? 3'd0 : kpos_mid;
      key_byte = (phase_mid == PH_SEEK_LON) ? LON_KEY[kpos_cur] : LAT_KEY[kpos_cur];
      if (data_byte == key_byte) begin
         kpos_new = 4'(kpos_cur) + 4'd1;
      end else begin
         kpos_new = (data_byte == CH_L) ? 4'd1 : 4'd0;
      end
      if ((phase_mid == PH_SEEK_LAT) || (phase_mid == PH_SEEK_LON)) begin
         if (kpos_new == 4'(KEY_LEN)) begin
            kpos_in  = 3'd0;
            phase_in = (phase_mid == PH_SEEK_LON) ? PH_LON_START : PH_LAT_START;
            neg_in   = 1'b0;
            point_in = 1'b0;
            fd_in    = 3'd0;
            acc_in   = '0;
         end else begin
            kpos_in = kpos_new[2:0];
         end
      end

      if (end_of_file) begin
         // A longitude still open at the last byte closes the pair.
         if ((phase_in == PH_LON_START) || (phase_in == PH_LON_BODY)) begin
            pair    = 1'b1;
            lon_val = signed_value(neg_in, acc_in);
         end
         phase_in = PH_SEEK_LAT;
         kpos_in  = 3'd0;
         neg_in   = 1'b0;
         point_in = 1'b0;
         fd_in    = 3'd0;
         acc_in   = '0;
         held_in  = '0;
      end
   end

   assign ev_push      = in_valid && (pair || end_of_file);
   assign ev.has_pair  = pair;
   assign ev.eof       = end_of_file;
   assign ev.latitude  = held_ff;
   assign ev.longitude = lon_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK_LAT;
         kpos_ff  <= 3'd0;
         neg_ff   <= 1'b0;
         point_ff <= 1'b0;
         fd_ff    <= 3'd0;
         acc_ff   <= '0;
         held_ff  <= '0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         kpos_ff  <= kpos_in;
         neg_ff   <= neg_in;
         point_ff <= point_in;
         fd_ff    <= fd_in;
         acc_ff   <= acc_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tpce_evq.sv =====
// Short event queue between the parser and the pair selector.
`default_nettype none
module tpce_evq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire tpce_pkg::event_type  push_event,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output tpce_pkg::event_type       head
);
   import tpce_pkg::*;

   localparam int PTR_W = $clog2(EVQ_DEPTH);
   localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

   event_type        mem_ff [EVQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(EVQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_event;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tpce_back.sv =====
// Pair selector: downsampling decision, counters and the result queue.
`default_nettype none
module tpce_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  ev_valid,
   input  wire tpce_pkg::event_type   ev,
   output logic                       ev_pop,
   input  wire logic [tpce_pkg::FOUND_W-1:0] total_points,
   input  wire logic                  pop,
   output logic                       empty,
   output tpce_pkg::result_type       res
);
   import tpce_pkg::*;

   localparam int PTR_W = $clog2(RESQ_DEPTH);
   localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

   result_type        resq_ff [RESQ_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              res_full, step, do_pop, wr_en;
   result_type        wr_data;

   logic [FOUND_W-1:0] found_ff, found_in, found_p;
   logic [KEPT_W-1:0]  kept_ff, kept_in, kept_p;
   logic [PROD_W-1:0]  itc_ff, itc_in, itc_p;
   logic [PROD_W-1:0]  kt_ff, kt_in, kt_p;
   logic               sum_pend_ff, sum_pend_in;
   logic               keep;

   assign res_full = (count_ff == CNT_W'(RESQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign res      = resq_ff[rd_ff];
   assign step     = ev_valid && !res_full;
   assign do_pop   = pop && !empty;

   // Keeps pair i if kept < MAX_POINTS and kept*total <= i*MAX_POINTS (running sums).
   always_comb begin
      keep = 1'b0;
      if (kept_ff < KEPT_W'(MAX_POINTS)) begin
         keep = (total_points <= FOUND_W'(MAX_POINTS)) || (kt_ff <= itc_ff);
      end
      kept_p  = kept_ff;
      kt_p    = kt_ff;
      found_p = found_ff;
      itc_p   = itc_ff;
      if (keep) begin
         kept_p = kept_ff + KEPT_W'(1);
         kt_p   = kt_ff + PROD_W'(total_points);
      end
      if (found_ff != FOUND_MAX) begin
         found_p = found_ff + FOUND_W'(1);
         itc_p   = itc_ff + PROD_W'(MAX_POINTS);
      end
   end

   always_comb begin
      ev_pop      = 1'b0;
      wr_en       = 1'b0;
      sum_pend_in = sum_pend_ff;
      found_in    = found_ff;
      kept_in     = kept_ff;
      itc_in      = itc_ff;
      kt_in       = kt_ff;
      wr_data.latitude    = '0;
      wr_data.longitude   = '0;
      wr_data.slot        = kept_ff;
      wr_data.pair_number = found_ff;
      wr_data.is_summary  = 1'b1;
      wr_data.last_of_run = 1'b1;
      if (step) begin
         if (sum_pend_ff || !ev.has_pair) begin
            // Summary with the counters as they stand, then a fresh file.
            wr_en       = 1'b1;
            ev_pop      = 1'b1;
            sum_pend_in = 1'b0;
            found_in    = '0;
            kept_in     = '0;
            itc_in      = '0;
            kt_in       = '0;
         end else begin
            found_in = found_p;
            kept_in  = kept_p;
            itc_in   = itc_p;
            kt_in    = kt_p;
            if (keep) begin
               wr_en               = 1'b1;
               wr_data.latitude    = ev.latitude;
               wr_data.longitude   = ev.longitude;
               wr_data.is_summary  = 1'b0;
               wr_data.last_of_run = !ev.eof;
               // The summary of a closing byte follows in the next step.
               sum_pend_in         = ev.eof;
               ev_pop              = !ev.eof;
            end else if (ev.eof) begin
               wr_en               = 1'b1;
               wr_data.slot        = kept_p;
               wr_data.pair_number = found_p;
               ev_pop              = 1'b1;
               found_in            = '0;
               kept_in             = '0;
               itc_in              = '0;
               kt_in               = '0;
            end else begin
               ev_pop = 1'b1;
            end
         end
      end
   end

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_in = (wr_ff == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (wr_en && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         count_ff    <= '0;
         sum_pend_ff <= 1'b0;
         found_ff    <= '0;
         kept_ff     <= '0;
         itc_ff      <= '0;
         kt_ff       <= '0;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         count_ff    <= count_in;
         sum_pend_ff <= sum_pend_in;
         found_ff    <= found_in;
         kept_ff     <= kept_in;
         itc_ff      <= itc_in;
         kt_ff       <= kt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         resq_ff[wr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/track_point_coordinate_extractor_top.sv =====
// Throughput: one byte per cycle; the parser takes a byte whenever the event queue has room.
// A result reaches the result ports through the event queue and then the result queue.
// The closing byte of a file whose last pair is kept gives the pair, then the summary.
// Reset is synchronous and clears the parser, counters, both queues and total_points.
// Top level of the track point coordinate extractor.
`default_nettype none
`include "track_point_coordinate_extractor_top_assert.svh"
module track_point_coordinate_extractor_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   output logic                                      full,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_end_of_file,
   output logic                                      empty,
   input  wire logic                                 pop,
   output logic signed [tpce_pkg::COORD_W-1:0]       rsp_latitude,
   output logic signed [tpce_pkg::COORD_W-1:0]       rsp_longitude,
   output logic [tpce_pkg::KEPT_W-1:0]               rsp_slot,
   output logic [tpce_pkg::FOUND_W-1:0]              rsp_pair_number,
   output logic                                      rsp_is_summary,
   output logic                                      rsp_last_of_run,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tpce_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [tpce_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tpce_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                      pready
);
   import tpce_pkg::*;

   logic [FOUND_W-1:0] total_ff;
   logic               csr_write;
   logic               accept;
   logic               ev_push;
   event_type          ev_in;
   logic               evq_valid;
   event_type          evq_head;
   logic               ev_pop;
   result_type         res;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                   && (paddr[2] == CSR_IDX_TOTAL_POINTS);
   assign prdata    = (paddr[2] == CSR_IDX_TOTAL_POINTS)
                    ? CSR_DATA_W'(total_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (csr_write) begin
         total_ff <= pwdata[FOUND_W-1:0];
      end
   end

   assign accept = push && !full;

   tpce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .ev_push     (ev_push),
      .ev          (ev_in)
   );

   tpce_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ev_push),
      .push_event (ev_in),
      .full       (full),
      .pop        (ev_pop),
      .head_valid (evq_valid),
      .head       (evq_head)
   );

   tpce_back u_back (
      .clock        (clock),
      .reset        (reset),
      .ev_valid     (evq_valid),
      .ev           (evq_head),
      .ev_pop       (ev_pop),
      .total_points (total_ff),
      .pop          (pop),
      .empty        (empty),
      .res          (res)
   );

   assign rsp_latitude    = res.latitude;
   assign rsp_longitude   = res.longitude;
   assign rsp_slot        = res.slot;
   assign rsp_pair_number = res.pair_number;
   assign rsp_is_summary  = res.is_summary;
   assign rsp_last_of_run = res.last_of_run;

   `TPCE_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), empty)
   `TPCE_ASSERT_NOW(a_summary_shape, clock, reset, !empty && rsp_is_summary, rsp_last_of_run && (rsp_latitude == 0) && (rsp_longitude == 0))
   `TPCE_ASSERT_NOW(a_slot_in_store, clock, reset, !empty && !rsp_is_summary, rsp_slot < KEPT_W'(MAX_POINTS))
   `TPCE_ASSERT_NEXT(a_no_result_without_event, clock, reset, empty && !evq_valid, empty)

endmodule
`default_nettype wire

// ===== tb/track_point_checker.sv =====
// Checker that predicts and compares the results of the track point coordinate extractor.
`default_nettype none
module track_point_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire logic                                 full,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_end_of_file,
   input  wire logic                                 empty,
   input  wire logic                                 pop,
   input  wire logic signed [tpce_pkg::COORD_W-1:0]  rsp_latitude,
   input  wire logic signed [tpce_pkg::COORD_W-1:0]  rsp_longitude,
   input  wire logic [tpce_pkg::KEPT_W-1:0]          rsp_slot,
   input  wire logic [tpce_pkg::FOUND_W-1:0]         rsp_pair_number,
   input  wire logic                                 rsp_is_summary,
   input  wire logic                                 rsp_last_of_run,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tpce_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [tpce_pkg::CSR_DATA_W-1:0]      pwdata,
   input  wire logic [tpce_pkg::CSR_DATA_W-1:0]      prdata,
   input  wire logic                                 pready,
   output int                                        failures,
   output int                                        pending,
   output int                                        results_checked,
   output int                                        summaries_checked,
   output bit                                        store_filled
);
   timeunit 1ns;
   timeprecision 1ps;
   import tpce_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TOTAL_POINTS_ADDR = CSR_ADDR_W'(4 * CSR_IDX_TOTAL_POINTS);

   logic [FOUND_W-1:0] total_points;
   phase_type          parse_phase;
   logic [2:0]         key_pos;
   logic               minus;
   logic               point_seen;
   logic [2:0]         frac_count;
   logic [COORD_W-1:0] magnitude;
   logic [COORD_W-1:0] held_lat;
   logic [FOUND_W-1:0] found_count;
   logic [KEPT_W-1:0]  kept_count;
   logic [63:0]        found_times_capacity;
   logic [63:0]        kept_times_setting;
   result_type         expected_points[$];

   function automatic logic [31:0] decade(input int unsigned n);
      logic [31:0] v;
      v = 32'd1;
      for (int i = 0; i < n; i++) v = v * 32'd10;
      return v;
   endfunction

   function automatic logic [7:0] key_char(input logic lon_key, input logic [2:0] pos);
      case (pos)
         3'd0: key_char = "l";
         3'd1: key_char = lon_key ? "o" : "a";
         3'd2: key_char = lon_key ? "n" : "t";
         3'd3: key_char = "=";
         default: key_char = 8'h22;
      endcase
   endfunction

   function automatic void clear_parser();
      parse_phase = PH_SEEK_LAT;
      key_pos = 3'd0;
      minus = 1'b0;
      point_seen = 1'b0;
      frac_count = 3'd0;
      magnitude = '0;
      held_lat = '0;
      found_count = '0;
      kept_count = '0;
      found_times_capacity = '0;
      kept_times_setting = '0;
   endfunction

   function automatic void open_number();
      minus = 1'b0;
      point_seen = 1'b0;
      frac_count = 3'd0;
      magnitude = '0;
   endfunction

   // Advances the key matcher and reports when the last key byte has just arrived.
   function automatic bit key_done(input logic lon_key, input logic [7:0] b);
      logic [2:0] p;
      p = (key_pos > 3'd4) ? 3'd0 : key_pos;
      if (b == key_char(lon_key, p)) p = p + 3'd1;
      else p = (b == "l") ? 3'd1 : 3'd0;
      if (p == 3'd5) begin
         key_pos = 3'd0;
         return 1'b1;
      end
      key_pos = p;
      return 1'b0;
   endfunction

   // Returns 0 when the byte does not belong to the open number.
   function automatic bit take_char(input logic [7:0] b, input bit first);
      logic [63:0] acc;
      logic [63:0] digit;
      acc = {32'd0, magnitude};
      digit = 64'(b) - 64'd48;
      if (first && (b == "-" || b == "+")) begin
         minus = (b == "-");
         return 1'b1;
      end
      if (b == "." && !point_seen) begin
         point_seen = 1'b1;
         return 1'b1;
      end
      if (b < "0" || b > "9") return 1'b0;
      if (!point_seen) begin
         acc = acc * 64'd10 + digit * decade(7);
      end else if (frac_count < 3'd7) begin
         frac_count = frac_count + 3'd1;
         if (frac_count <= FRACTION_DIGITS) acc = acc + digit * decade(7 - frac_count);
      end
      magnitude = (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[31:0];
      return 1'b1;
   endfunction

   function automatic logic [31:0] signed_value();
      return minus ? (32'd0 - magnitude) : magnitude;
   endfunction

   function automatic void close_pair(input logic [31:0] lon);
      result_type r;
      bit keep;
      keep = 1'b0;
      if (kept_count < MAX_POINTS) begin
         if (total_points <= MAX_POINTS) keep = 1'b1;
         else keep = (kept_times_setting <= found_times_capacity);
      end
      if (keep) begin
         r.latitude = held_lat;
         r.longitude = lon;
         r.slot = kept_count;
         r.pair_number = found_count;
         r.is_summary = 1'b0;
         r.last_of_run = 1'b0;
         expected_points.push_back(r);
         kept_count = kept_count + 1'b1;
         kept_times_setting = kept_times_setting + 64'(total_points);
      end
      if (found_count < FOUND_MAX) begin
         found_count = found_count + 1'b1;
         found_times_capacity = found_times_capacity + 64'(MAX_POINTS);
      end
   endfunction

   function automatic void parse_route_byte(input logic [7:0] b, input logic eof);
      int first_new;
      result_type r;
      first_new = expected_points.size();
      if (parse_phase == PH_LAT_START || parse_phase == PH_LAT_BODY) begin
         if (take_char(b, parse_phase == PH_LAT_START)) begin
            parse_phase = PH_LAT_BODY;
         end else begin
            held_lat = signed_value();
            parse_phase = PH_SEEK_LON;
            key_pos = 3'd0;
         end
      end else if (parse_phase == PH_LON_START || parse_phase == PH_LON_BODY) begin
         if (take_char(b, parse_phase == PH_LON_START)) begin
            parse_phase = PH_LON_BODY;
         end else begin
            close_pair(signed_value());
            parse_phase = PH_SEEK_LAT;
            key_pos = 3'd0;
         end
      end
      if (parse_phase == PH_SEEK_LAT) begin
         if (key_done(1'b0, b)) begin
            parse_phase = PH_LAT_START;
            open_number();
         end
      end else if (parse_phase == PH_SEEK_LON) begin
         if (key_done(1'b1, b)) begin
            parse_phase = PH_LON_START;
            open_number();
         end
      end
      // The closing byte flushes an open longitude and always adds the summary.
      if (eof) begin
         if (parse_phase == PH_LON_START || parse_phase == PH_LON_BODY)
            close_pair(signed_value());
         r.latitude = '0;
         r.longitude = '0;
         r.slot = kept_count;
         r.pair_number = found_count;
         r.is_summary = 1'b1;
         r.last_of_run = 1'b0;
         expected_points.push_back(r);
         clear_parser();
      end
      if (expected_points.size() > first_new) begin
         r = expected_points.pop_back();
         r.last_of_run = 1'b1;
         expected_points.push_back(r);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         total_points = '0;
         clear_parser();
         expected_points.delete();
         failures = 0;
         pending = 0;
         results_checked = 0;
         summaries_checked = 0;
         store_filled = 1'b0;
      end else begin
         if (psel && penable && pready && paddr == TOTAL_POINTS_ADDR) begin
            if (pwrite) begin
               total_points = pwdata[FOUND_W-1:0];
            end else if (prdata !== CSR_DATA_W'(total_points)) begin
               $error("total_points mismatch: expected %0d, got %0d", total_points, prdata);
               failures++;
            end
         end
         if (pop && !empty) begin
            results_checked++;
            if (expected_points.size() == 0) begin
               $error("result transaction arrived with nothing expected");
               failures++;
            end else begin
               want = expected_points.pop_front();
               check_field("latitude", 64'(want.latitude), 64'(rsp_latitude));
               check_field("longitude", 64'(want.longitude), 64'(rsp_longitude));
               check_field("slot", 64'(want.slot), 64'(rsp_slot));
               check_field("pair_number", 64'(want.pair_number), 64'(rsp_pair_number));
               check_field("is_summary", 64'(want.is_summary), 64'(rsp_is_summary));
               check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_last_of_run));
               if (want.is_summary) summaries_checked++;
               else if (want.slot == MAX_POINTS - 1) store_filled = 1'b1;
            end
         end
         if (push && !full) parse_route_byte(req_data_byte, req_end_of_file);
         pending = expected_points.size();
      end
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the testbench: drives route text and register settings into the extractor.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tpce_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TOTAL_POINTS_ADDR = CSR_ADDR_W'(4 * CSR_IDX_TOTAL_POINTS);
   localparam int PHASES        = 9;
   localparam int PHASE_BYTES   = 150;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 5000;
   localparam int BURST_PAIRS   = 12;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic [7:0]                   req_data_byte = '0;
   logic                         req_end_of_file = 1'b0;
   logic                         pop = 1'b0;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        paddr = '0;
   logic [CSR_DATA_W-1:0]        pwdata = '0;
   wire logic                    full;
   wire logic                    empty;
   wire logic signed [COORD_W-1:0] rsp_latitude;
   wire logic signed [COORD_W-1:0] rsp_longitude;
   wire logic [KEPT_W-1:0]       rsp_slot;
   wire logic [FOUND_W-1:0]      rsp_pair_number;
   wire logic                    rsp_is_summary;
   wire logic                    rsp_last_of_run;
   wire logic [CSR_DATA_W-1:0]   prdata;
   wire logic                    pready;

   int failures;
   int pending;
   int results_checked;
   int summaries_checked;
   bit store_filled;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int bytes_sent = 0;
   int files_sent = 0;
   int quiet_cycles = 0;
   logic [7:0] route_text[$];

   track_point_coordinate_extractor_top uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_end_of_file(req_end_of_file),
      .empty(empty), .pop(pop),
      .rsp_latitude(rsp_latitude), .rsp_longitude(rsp_longitude),
      .rsp_slot(rsp_slot), .rsp_pair_number(rsp_pair_number),
      .rsp_is_summary(rsp_is_summary), .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   track_point_checker points_check (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_end_of_file(req_end_of_file),
      .empty(empty), .pop(pop),
      .rsp_latitude(rsp_latitude), .rsp_longitude(rsp_longitude),
      .rsp_slot(rsp_slot), .rsp_pair_number(rsp_pair_number),
      .rsp_is_summary(rsp_is_summary), .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .failures(failures), .pending(pending),
      .results_checked(results_checked), .summaries_checked(summaries_checked),
      .store_filled(store_filled)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("track_point_coordinate_extractor_top verification failed");
         $finish;
      end
   end

   // Result side: one long hold-off when asked, otherwise random pops.
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= b;
      req_end_of_file <= eof;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_route();
      for (int i = 0; i < route_text.size(); i++)
         send_byte(route_text[i], i == route_text.size() - 1);
      route_text.delete();
      files_sent++;
   endtask

   // Waits until every expected result has been taken and the pipeline has had time to drain.
   task automatic settle();
      int calm;
      push <= 1'b0;
      calm = 0;
      while (calm < SETTLE_CYCLES) begin
         @(negedge clock);
         if (pending == 0) calm++;
         else calm = 0;
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= TOTAL_POINTS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) route_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] digit_char();
      return 8'h30 + 8'($urandom_range(9));
   endfunction

   task automatic queue_number();
      int sel;
      int whole;
      int part;
      sel = $urandom_range(99);
      if (sel >= 90) queue_text(sel[0] ? "+-" : "--");
      else if (sel >= 80) queue_text("+");
      else if (sel >= 60) queue_text("-");
      whole = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3);
      repeat (whole) route_text.push_back(digit_char());
      if ($urandom_range(99) < 60) begin
         route_text.push_back(".");
         part = $urandom_range(9);
         repeat (part) route_text.push_back(digit_char());
         if ($urandom_range(19) == 0) route_text.push_back(".");
      end
   endtask

   task automatic queue_closer();
      int sel;
      sel = $urandom_range(99);
      if (sel < 80) route_text.push_back(8'h22);
      else if (sel < 90) route_text.push_back(" ");
      else route_text.push_back(8'($urandom));
   endtask

   task automatic build_route();
      int fragments;
      int pick;
      fragments = $urandom_range(6);
      for (int f = 0; f < fragments; f++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            queue_text("<trkpt lat=\"");
            queue_number();
            queue_closer();
            queue_text(" lon=\"");
            queue_number();
            queue_closer();
            queue_text("/>\n");
         end else if (pick < 75) begin
            queue_text("lat=\"");
            queue_number();
            queue_closer();
            queue_text("lat=\"");
            queue_number();
            queue_closer();
         end else if (pick < 88) begin
            case ($urandom_range(4))
               0: queue_text("la=\"1\"");
               1: queue_text("lat\"2\" lon=3");
               2: queue_text("llat=\"4\"lolon=\"5\"");
               3: queue_text("lon=\"6\"");
               default: queue_text("lat=\"lon=\"");
            endcase
         end else begin
            repeat ($urandom_range(8, 1)) route_text.push_back(8'($urandom));
         end
      end
      // Often end the file inside a longitude so the closing byte must flush the pair.
      if ($urandom_range(3) == 0) begin
         queue_text(" lat=\"");
         queue_number();
         queue_closer();
         queue_text("lon=\"");
         queue_number();
      end
      if (route_text.size() == 0) route_text.push_back(8'($urandom));
   endtask

   function automatic logic [CSR_DATA_W-1:0] phase_setting(input int ph);
      case (ph)
         0: return '0;
         1: return CSR_DATA_W'(MAX_POINTS + 1);
         2: return CSR_DATA_W'(20000);
         3: return CSR_DATA_W'(FOUND_MAX);
         4: return CSR_DATA_W'(MAX_POINTS);
         5: return CSR_DATA_W'(1);
         6: return {8'($urandom), 24'($urandom_range(FOUND_MAX, MAX_POINTS + 2))};
         7: return CSR_DATA_W'($urandom_range(MAX_POINTS - 1, 2));
         default: return '0;
      endcase
   endfunction

   initial begin
      int start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         csr_access(1'b1, phase_setting(ph));
         csr_access(1'b0, '0);
         send_idle_pct = (ph < 3) ? 17 : (ph < 6) ? 80 : 0;
         recv_idle_pct = (ph < 3) ? 80 : (ph < 6) ? 17 : 0;
         start = bytes_sent;
         if (ph == 0) begin
            // Fraction truncation, magnitude saturation, end of file inside a longitude.
            queue_text("lat=\"-.123456789lon=\"999");
            send_route();
            // Minus zero with no digits, then a pair closed by the final byte.
            queue_text("lat=\"-lon=\"0");
            send_route();
            // A sign after the first character, and a latitude with no longitude.
            queue_text("lat=\"+-7");
            send_route();
         end
         if (ph == 1) begin
            // A dense file while results are held back, so both queues fill up.
            hold_request = 1'b1;
            repeat (BURST_PAIRS) queue_text("lat=\"1\" lon=\"2\" ");
            send_route();
         end
         while (bytes_sent - start < PHASE_BYTES) begin
            build_route();
            send_route();
         end
      end
      settle();
      $display("Run covered %0d bytes in %0d route files across %0d register settings.",
               bytes_sent, files_sent, PHASES);
      $display("Checked %0d results, %0d of them summaries; point store filled: %s.",
               results_checked, summaries_checked, store_filled ? "yes" : "no");
      if (failures == 0) begin
         $display("track_point_coordinate_extractor_top verification clean");
      end else begin
         $display("track_point_coordinate_extractor_top verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
